// ----- rtl/core/snd_pkg.sv -----
// Shared types, codes and coil lookup for the stepper needle driver.
package snd_pkg;

    localparam logic       FUNC_TICK = 1'b0;
    localparam logic       FUNC_LOAD = 1'b1;

    localparam logic [1:0] DIR_STOP  = 2'd0;
    localparam logic [1:0] DIR_UP    = 2'd1;
    localparam logic [1:0] DIR_DOWN  = 2'd2;

    localparam logic [2:0] PHASE_LAST = 3'd5;

    localparam int unsigned FIELD_POS_BITS = 10;

    typedef struct packed {
        logic                      func;
        logic [FIELD_POS_BITS-1:0] goal_step;
        logic [FIELD_POS_BITS-1:0] new_position;
    } t_req;

    typedef struct packed {
        logic [3:0]                coil_drive;
        logic [2:0]                phase_index;
        logic [FIELD_POS_BITS-1:0] position_now;
        logic [3:0]                interval_mode;
        logic [1:0]                step_dir;
    } t_res;

    function automatic logic [3:0] coil_pattern(input logic [2:0] phase);
        logic [3:0] pat;
        case (phase)
            3'd0:    pat = 4'd9;
            3'd1:    pat = 4'd1;
            3'd2:    pat = 4'd4;
            3'd3:    pat = 4'd6;
            3'd4:    pat = 4'd2;
            3'd5:    pat = 4'd8;
            default: pat = 4'd0;
        endcase
        return pat;
    endfunction

endpackage

// ----- rtl/core/snd_out_queue.sv -----
// Two-entry result buffer between the update stage and the output channel.
module snd_out_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  snd_pkg::t_res i_push_res,
    output logic          o_space,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output snd_pkg::t_res o_out_res
);

    logic          r_q0_v;
    logic          r_q1_v;
    snd_pkg::t_res r_q0;
    snd_pkg::t_res r_q1;
    logic          w_pop;

    assign w_pop       = r_q0_v && !i_out_stall;
    assign o_space     = !r_q1_v || w_pop;
    assign o_out_valid = r_q0_v;
    assign o_out_res   = r_q0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q0_v <= 1'b0;
            r_q1_v <= 1'b0;
        end else if (w_pop) begin
            r_q0_v <= r_q1_v || i_push;
            r_q1_v <= r_q1_v && i_push;
        end else if (i_push) begin
            r_q0_v <= 1'b1;
            r_q1_v <= r_q0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            if (r_q1_v) begin
                r_q0 <= r_q1;
                if (i_push) begin
                    r_q1 <= i_push_res;
                end
            end else if (i_push) begin
                r_q0 <= i_push_res;
            end
        end else if (i_push) begin
            if (r_q0_v) begin
                r_q1 <= i_push_res;
            end else begin
                r_q0 <= i_push_res;
            end
        end
    end

endmodule

// ----- rtl/core/stepper_needle_driver_with_ramp_unit.sv -----
// Top level: six-phase stepper needle driver with acceleration ramp.
//
// Input channel: i_in_valid / o_in_stall carry one request (i_in_req). A
// step tick moves the needle one step toward goal_step, shifts the
// direction history, turns the coil phase by the direction leaving the
// oldest slot and ramps the interval mode. A load request forces the
// position and leaves phase, mode and history alone.
// Output channel: o_out_valid / i_out_stall carry one result per request.
// Path: a request is registered on acceptance, and its result is registered
// in the result buffer. Throughput: one request per cycle while the buffer
// has space; the update is one shallow pass of logic between the request
// register and a two-entry result buffer.
// Reset: position 0, phase 0, mode at the slowest setting, history all stop,
// both channels empty.
// Receiver stall: results collect in the buffer; when it is full the
// request register holds and o_in_stall rises, no result is dropped.
module stepper_needle_driver_with_ramp_unit #(
    parameter int unsigned SLOWEST_MODE  = 13,
    parameter int unsigned FASTEST_MODE  = 4,
    parameter int unsigned HISTORY_DEPTH = 9,
    parameter int unsigned POSITION_BITS = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  snd_pkg::t_req i_in_req,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output snd_pkg::t_res o_out_res
);

    localparam int unsigned FB = snd_pkg::FIELD_POS_BITS;

    logic                     r_req_v;
    snd_pkg::t_req            r_req;
    logic [POSITION_BITS-1:0] r_pos;
    logic [2:0]               r_phase;
    logic [3:0]               r_mode;
    logic [1:0]               r_hist [HISTORY_DEPTH];

    logic [POSITION_BITS-1:0] n_pos;
    logic [2:0]               n_phase;
    logic [3:0]               n_mode;
    logic [1:0]               w_dir;
    logic [POSITION_BITS-1:0] w_target;
    logic [POSITION_BITS-1:0] w_load;
    logic                     w_mismatch;
    logic                     w_adv;
    logic                     w_space;
    logic                     w_tick;
    snd_pkg::t_res            w_res;

    assign w_adv      = r_req_v && w_space;
    assign o_in_stall = r_req_v && !w_space;
    assign w_tick     = (r_req.func == snd_pkg::FUNC_TICK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_v <= 1'b0;
        end else if (!o_in_stall) begin
            r_req_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_req <= i_in_req;
        end
    end

    for (genvar b = 0; b < POSITION_BITS; b++) begin : g_pos_in
        if (b < FB) begin : g_fld
            assign w_target[b] = r_req.goal_step[b];
            assign w_load[b]   = r_req.new_position[b];
        end else begin : g_pad
            assign w_target[b] = 1'b0;
            assign w_load[b]   = 1'b0;
        end
    end

    always_comb begin
        w_mismatch = 1'b0;
        for (int i = 1; i < HISTORY_DEPTH; i++) begin
            if (r_hist[i] != w_dir) begin
                w_mismatch = 1'b1;
            end
        end
    end

    always_comb begin
        n_pos   = r_pos;
        n_phase = r_phase;
        n_mode  = r_mode;
        w_dir   = snd_pkg::DIR_STOP;
        if (!w_tick) begin
            n_pos = w_load;
        end else begin
            if (r_pos > w_target) begin
                w_dir = snd_pkg::DIR_DOWN;
                n_pos = r_pos - 1'b1;
            end else if (r_pos < w_target) begin
                w_dir = snd_pkg::DIR_UP;
                n_pos = r_pos + 1'b1;
            end
            if (r_hist[0] == snd_pkg::DIR_DOWN) begin
                n_phase = (r_phase >= snd_pkg::PHASE_LAST) ? 3'd0 : r_phase + 3'd1;
            end else if (r_hist[0] == snd_pkg::DIR_UP) begin
                n_phase = (r_phase == 3'd0) ? snd_pkg::PHASE_LAST : r_phase - 3'd1;
            end
            if (w_mismatch) begin
                if (r_mode < 4'(SLOWEST_MODE)) begin
                    n_mode = r_mode + 4'd1;
                end
            end else if (r_mode > 4'(FASTEST_MODE)) begin
                n_mode = r_mode - 4'd1;
            end
        end
    end

    always_comb begin
        w_res.coil_drive    = snd_pkg::coil_pattern(n_phase);
        w_res.phase_index   = n_phase;
        w_res.interval_mode = r_mode;
        w_res.step_dir      = w_dir;
        for (int b = 0; b < FB; b++) begin
            w_res.position_now[b] = (b < POSITION_BITS) ? n_pos[b] : 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_phase <= 3'd0;
            r_mode  <= 4'(SLOWEST_MODE);
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                r_hist[i] <= snd_pkg::DIR_STOP;
            end
        end else if (w_adv) begin
            r_pos   <= n_pos;
            r_phase <= n_phase;
            r_mode  <= n_mode;
            if (w_tick) begin
                for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
                    r_hist[i] <= r_hist[i+1];
                end
                r_hist[HISTORY_DEPTH-1] <= w_dir;
            end
        end
    end

    snd_out_queue u_out_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_adv),
        .i_push_res  (w_res),
        .o_space     (w_space),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_res   (o_out_res)
    );

endmodule
